FILE: design/xpath_step_recognizer_top_macros.svh
// ---------------------------------------------------------------------------
// XPath step recognizer assertion macros
// Shared concurrent assertion forms; each expects clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef XPATH_STEP_RECOGNIZER_TOP_MACROS_SVH
`define XPATH_STEP_RECOGNIZER_TOP_MACROS_SVH

// condition holds whenever the antecedent holds
`define XSR_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xpath step recognizer: same-cycle check failed");

// condition holds in the cycle after the antecedent
`define XSR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xpath step recognizer: next-cycle check failed");

`endif

FILE: design/xsr_pkg.sv
// ---------------------------------------------------------------------------
// XPath step recognizer package
// Sizes, character codes, result codes, keyword tables and helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package xsr_pkg;

    localparam int MAX_LEN = 256;
    localparam int POS_W   = $clog2(MAX_LEN + 1);
    localparam int KW_IDX_W = 4;
    localparam int KW_TXT_W = 88;

    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_PRED  = 2'd1;
    localparam logic [1:0] ST_VALUE = 2'd2;
    localparam logic [1:0] ST_ERROR = 2'd3;

    localparam logic [1:0] AXIS_UNKNOWN   = 2'd0;
    localparam logic [1:0] AXIS_ATTRIBUTE = 2'd1;

    localparam logic [1:0] KW_ATTR   = 2'd0;
    localparam logic [1:0] KW_CHILD  = 2'd1;
    localparam logic [1:0] KW_PARENT = 2'd2;

    localparam logic [KW_TXT_W-1:0] KW_ATTR_TXT   = "attribute::";
    localparam logic [KW_TXT_W-1:0] KW_CHILD_TXT  = {"child::", 32'h0};
    localparam logic [KW_TXT_W-1:0] KW_PARENT_TXT = {"parent::", 24'h0};

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } in_beat_t;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] step_type;
        logic       name_given;
        logic [7:0] name_start;
        logic [7:0] name_len;
        logic [1:0] pred_type;
        logic       pred_name_given;
        logic [7:0] pred_name_start;
        logic [7:0] pred_name_len;
        logic [7:0] value_start;
        logic [7:0] value_len;
    } res_t;

    function automatic logic [KW_IDX_W-1:0] kw_len(input logic [1:0] k);
        logic [KW_IDX_W-1:0] len;
        unique case (k)
            KW_ATTR:   len = KW_IDX_W'(11);
            KW_CHILD:  len = KW_IDX_W'(7);
            KW_PARENT: len = KW_IDX_W'(8);
            default:   len = '0;
        endcase
        return len;
    endfunction

    function automatic logic kw_hit(input logic [1:0] k, input logic [KW_IDX_W-1:0] idx,
                                    input logic [7:0] c);
        logic [KW_TXT_W-1:0] txt;
        logic [KW_TXT_W-1:0] sh;
        unique case (k)
            KW_ATTR:   txt = KW_ATTR_TXT;
            KW_CHILD:  txt = KW_CHILD_TXT;
            KW_PARENT: txt = KW_PARENT_TXT;
            default:   txt = '0;
        endcase
        sh = txt << {idx, 3'b000};
        return (idx < kw_len(k)) && (sh[KW_TXT_W-1 -: 8] == c);
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        return (c == CH_LBRACK) || (c == CH_EQ) || (c == CH_RBRACK) || is_ws(c);
    endfunction

    function automatic logic [7:0] sat8(input logic [POS_W-1:0] v);
        logic [POS_W+7:0] w;
        w = {8'd0, v};
        return (w > (POS_W+8)'(255)) ? 8'hFF : w[7:0];
    endfunction

endpackage

`default_nettype wire

FILE: design/xsr_char_if.sv
// ---------------------------------------------------------------------------
// XPath step recognizer character channel
// Valid/ready channel carrying one expression character per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface xsr_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last;

    modport source (output valid, char_code, last, input ready);
    modport sink   (input valid, char_code, last, output ready);
endinterface

`default_nettype wire

FILE: design/xsr_step_if.sv
// ---------------------------------------------------------------------------
// XPath step recognizer result channel
// Valid/ready channel carrying one recognized step per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface xsr_step_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [1:0] step_type;
    logic       name_given;
    logic [7:0] name_start;
    logic [7:0] name_len;
    logic [1:0] pred_type;
    logic       pred_name_given;
    logic [7:0] pred_name_start;
    logic [7:0] pred_name_len;
    logic [7:0] value_start;
    logic [7:0] value_len;

    modport source (output valid, status, step_type, name_given, name_start, name_len,
                    pred_type, pred_name_given, pred_name_start, pred_name_len,
                    value_start, value_len, input ready);
    modport sink   (input valid, status, step_type, name_given, name_start, name_len,
                    pred_type, pred_name_given, pred_name_start, pred_name_len,
                    value_start, value_len, output ready);
endinterface

`default_nettype wire

FILE: design/xsr_in_stage.sv
// ---------------------------------------------------------------------------
// XPath step recognizer input stage
// Registers one character beat and frees itself as the parser consumes it.
// ---------------------------------------------------------------------------
`default_nettype none

module xsr_in_stage (
    input  wire logic      clk,
    input  wire logic      rst_n,
    xsr_char_if.sink       chars,
    input  wire logic      take,
    output logic           vld,
    output xsr_pkg::in_beat_t beat
);
    import xsr_pkg::*;

    logic     vld_reg;
    in_beat_t beat_reg;

    assign chars.ready = !vld_reg || take;
    assign vld         = vld_reg;
    assign beat        = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (chars.valid && chars.ready)
        begin
            vld_reg <= 1'b1;
        end
        else if (take)
        begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            beat_reg.char_code <= chars.char_code;
            beat_reg.last      <= chars.last;
        end
    end

endmodule

`default_nettype wire

FILE: design/xsr_core.sv
// ---------------------------------------------------------------------------
// XPath step recognizer parser core
// Per-character state transition, keyword match, position tracking and
// end-of-expression result assembly.
// ---------------------------------------------------------------------------
`default_nettype none

module xsr_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         vld,
    input  wire xsr_pkg::in_beat_t beat,
    input  wire logic         can_push,
    output logic              take,
    output logic              push,
    output xsr_pkg::res_t     res
);
    import xsr_pkg::*;

    typedef enum logic [3:0] {
        PH_S_AXIS,
        PH_S_NSTART,
        PH_S_NAME,
        PH_P_AXIS,
        PH_P_NSTART,
        PH_P_NAME,
        PH_P_EQ,
        PH_P_QUOTE,
        PH_P_VALUE,
        PH_DONE,
        PH_ERROR
    } phase_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [1:0]       step_type;
        logic             name_given;
        logic [POS_W-1:0] name_start;
        logic [POS_W-1:0] name_len;
        logic [1:0]       pred_type;
        logic             pred_name_given;
        logic [POS_W-1:0] pred_start;
        logic [POS_W-1:0] pred_len;
        logic [POS_W-1:0] value_start;
        logic [POS_W-1:0] value_len;
    } kept_t;

    phase_t              phase_reg, phase_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [2:0]          cand_reg, cand_next;
    logic [KW_IDX_W-1:0] pidx_reg, pidx_next;
    logic [7:0]          quote_reg, quote_next;
    logic                fin_reg, fin_next;
    kept_t               kept_reg, kept_next;

    logic       go;
    logic       pred;
    logic       err;
    logic [2:0] m;
    logic [7:0] c;
    kept_t      kf;

    assign take = vld && (!beat.last || can_push);
    assign push = take && beat.last;

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        cand_next  = cand_reg;
        pidx_next  = pidx_reg;
        quote_next = quote_reg;
        fin_next   = fin_reg;
        kept_next  = kept_reg;
        go         = 1'b0;
        pred       = 1'b0;
        m          = '0;
        c          = beat.char_code;

        if (!fin_reg)
        begin
            if (c == 8'd0)
            begin
                fin_next = 1'b1;
            end
            else if (pos_reg < POS_W'(MAX_LEN))
            begin
                go       = (phase_reg != PH_ERROR);
                pos_next = pos_reg + 1'b1;
            end
            else
            begin
                phase_next = PH_ERROR;
            end
        end

        // axis prefix
        if (go && (phase_next == PH_S_AXIS || phase_next == PH_P_AXIS))
        begin
            pred = (phase_next == PH_P_AXIS);
            if (pidx_reg == '0 && c == CH_AT)
            begin
                if (pred)
                    kept_next.pred_type = AXIS_ATTRIBUTE;
                else
                    kept_next.step_type = AXIS_ATTRIBUTE;
                phase_next = pred ? PH_P_NSTART : PH_S_NSTART;
                go = 1'b0;
            end
            else
            begin
                for (int k = 0; k < 3; k++)
                    m[k] = cand_reg[k] && kw_hit(2'(k), pidx_reg, c);
                if (m == '0)
                begin
                    if (pidx_reg == '0)
                    begin
                        phase_next = pred ? PH_P_NSTART : PH_S_NSTART;
                    end
                    else
                    begin
                        if (pred)
                            kept_next.pred_name_given = 1'b1;
                        else
                            kept_next.name_given = 1'b1;
                        phase_next = pred ? PH_P_NAME : PH_S_NAME;
                    end
                end
                else
                begin
                    cand_next = m;
                    pidx_next = pidx_reg + 1'b1;
                    for (int k = 0; k < 3; k++)
                    begin
                        if (m[k] && pidx_next == kw_len(2'(k)))
                        begin
                            if (pred)
                                kept_next.pred_type = 2'(k + 1);
                            else
                                kept_next.step_type = 2'(k + 1);
                            phase_next = pred ? PH_P_NSTART : PH_S_NSTART;
                        end
                    end
                    go = 1'b0;
                end
            end
        end

        // name start
        if (go && (phase_next == PH_S_NSTART || phase_next == PH_P_NSTART))
        begin
            pred = (phase_next == PH_P_NSTART);
            if (c == CH_LBRACK)
            begin
                if (pred)
                begin
                    kept_next.status = ST_PRED;
                    phase_next = PH_DONE;
                end
                else
                begin
                    phase_next = PH_P_AXIS;
                    kept_next.pred_start = pos_reg + 1'b1;
                    cand_next = 3'b111;
                    pidx_next = '0;
                end
                go = 1'b0;
            end
            else if (pred)
            begin
                kept_next.pred_name_given = 1'b1;
                kept_next.pred_start = pos_reg;
                phase_next = PH_P_NAME;
            end
            else
            begin
                kept_next.name_given = 1'b1;
                kept_next.name_start = pos_reg;
                phase_next = PH_S_NAME;
            end
        end

        if (go && phase_next == PH_S_NAME)
        begin
            if (is_delim(c))
            begin
                kept_next.name_len = pos_reg - kept_next.name_start;
                if (c == CH_LBRACK)
                begin
                    phase_next = PH_P_AXIS;
                    kept_next.pred_start = pos_reg + 1'b1;
                    cand_next = 3'b111;
                    pidx_next = '0;
                end
                else
                begin
                    kept_next.status = ST_OK;
                    phase_next = PH_DONE;
                end
            end
            go = 1'b0;
        end

        if (go && phase_next == PH_P_NAME)
        begin
            if (is_delim(c))
            begin
                kept_next.pred_len = pos_reg - kept_next.pred_start;
                phase_next = PH_P_EQ;
            end
            else
            begin
                go = 1'b0;
            end
        end

        if (go && phase_next == PH_P_EQ)
        begin
            if (!is_ws(c))
            begin
                if (c == CH_EQ)
                begin
                    phase_next = PH_P_QUOTE;
                end
                else
                begin
                    kept_next.status = ST_PRED;
                    phase_next = PH_DONE;
                end
            end
            go = 1'b0;
        end

        if (go && phase_next == PH_P_QUOTE)
        begin
            if (!is_ws(c))
            begin
                quote_next = c;
                kept_next.value_start = pos_reg + 1'b1;
                phase_next = PH_P_VALUE;
            end
            go = 1'b0;
        end

        if (go && phase_next == PH_P_VALUE)
        begin
            if (c == quote_reg)
            begin
                kept_next.value_len = pos_reg - kept_next.value_start;
                kept_next.status = ST_VALUE;
                phase_next = PH_DONE;
            end
        end
    end

    // close the expression and assemble the result
    always_comb
    begin
        kf  = kept_next;
        err = 1'b0;
        res = '0;

        unique case (phase_next)
            PH_S_AXIS:
            begin
                if (pos_next == '0)
                begin
                    err = 1'b1;
                end
                else
                begin
                    kf.name_given = 1'b1;
                    kf.name_len   = POS_W'(pidx_next);
                    kf.status     = ST_OK;
                end
            end
            PH_P_AXIS:
            begin
                if (pidx_next != '0)
                begin
                    kf.pred_name_given = 1'b1;
                    kf.pred_len        = POS_W'(pidx_next);
                end
                kf.status = ST_PRED;
            end
            PH_S_NSTART: kf.status = ST_OK;
            PH_P_NSTART: kf.status = ST_PRED;
            PH_S_NAME:
            begin
                kf.name_len = pos_next - kf.name_start;
                kf.status   = ST_OK;
            end
            PH_P_NAME:
            begin
                kf.pred_len = pos_next - kf.pred_start;
                kf.status   = ST_PRED;
            end
            PH_P_EQ:     kf.status = ST_PRED;
            PH_DONE:     kf.status = kept_next.status;
            default:     err = 1'b1;
        endcase

        res.status = err ? ST_ERROR : kf.status;
        if (!err)
        begin
            res.step_type  = kf.step_type;
            res.name_given = kf.name_given;
            if (kf.name_given)
            begin
                res.name_start = sat8(kf.name_start);
                res.name_len   = sat8(kf.name_len);
            end
            if (kf.status != ST_OK)
            begin
                res.pred_type       = kf.pred_type;
                res.pred_name_given = kf.pred_name_given;
                if (kf.pred_name_given)
                begin
                    res.pred_name_start = sat8(kf.pred_start);
                    res.pred_name_len   = sat8(kf.pred_len);
                end
            end
            if (kf.status == ST_VALUE)
            begin
                res.value_start = sat8(kf.value_start);
                res.value_len   = sat8(kf.value_len);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_S_AXIS;
            pos_reg   <= '0;
            cand_reg  <= 3'b111;
            pidx_reg  <= '0;
            quote_reg <= '0;
            fin_reg   <= 1'b0;
            kept_reg  <= '0;
        end
        else if (take)
        begin
            if (beat.last)
            begin
                phase_reg <= PH_S_AXIS;
                pos_reg   <= '0;
                cand_reg  <= 3'b111;
                pidx_reg  <= '0;
                quote_reg <= '0;
                fin_reg   <= 1'b0;
                kept_reg  <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                cand_reg  <= cand_next;
                pidx_reg  <= pidx_next;
                quote_reg <= quote_next;
                fin_reg   <= fin_next;
                kept_reg  <= kept_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/xsr_out_stage.sv
// ---------------------------------------------------------------------------
// XPath step recognizer output stage
// Result register driving the step channel; accepts a new result as the
// current one leaves.
// ---------------------------------------------------------------------------
`default_nettype none

module xsr_out_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire xsr_pkg::res_t res,
    output logic               can_push,
    xsr_step_if.source         steps
);
    import xsr_pkg::*;

    logic valid_reg;
    res_t res_reg;

    assign can_push = !valid_reg || steps.ready;

    assign steps.valid           = valid_reg;
    assign steps.status          = res_reg.status;
    assign steps.step_type       = res_reg.step_type;
    assign steps.name_given      = res_reg.name_given;
    assign steps.name_start      = res_reg.name_start;
    assign steps.name_len        = res_reg.name_len;
    assign steps.pred_type       = res_reg.pred_type;
    assign steps.pred_name_given = res_reg.pred_name_given;
    assign steps.pred_name_start = res_reg.pred_name_start;
    assign steps.pred_name_len   = res_reg.pred_name_len;
    assign steps.value_start     = res_reg.value_start;
    assign steps.value_len       = res_reg.value_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push)
        begin
            valid_reg <= 1'b1;
        end
        else if (steps.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire

FILE: design/xpath_step_recognizer_top.sv
// ---------------------------------------------------------------------------
// XPath step recognizer
// Parses one XPath step a character per beat and reports axis, name and
// predicate positions on the final character.
// ---------------------------------------------------------------------------
// One character beat is taken every cycle; each beat passes the input
// register, the combinational parse logic and the result register, so the
// result of an expression is on the step channel in the cycle after its last
// beat is taken. The character side stalls only when a last beat waits for the
// result register to free up. No clearing pass is needed after reset.
`default_nettype none

`include "xpath_step_recognizer_top_macros.svh"

module xpath_step_recognizer_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    xsr_char_if.sink   chars,
    xsr_step_if.source steps
);
    import xsr_pkg::*;

    logic     in_vld;
    in_beat_t in_beat;
    logic     take;
    logic     push;
    logic     can_push;
    res_t     res;

    xsr_in_stage u_in (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars),
        .take  (take),
        .vld   (in_vld),
        .beat  (in_beat)
    );

    xsr_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .vld      (in_vld),
        .beat     (in_beat),
        .can_push (can_push),
        .take     (take),
        .push     (push),
        .res      (res)
    );

    xsr_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .res      (res),
        .can_push (can_push),
        .steps    (steps)
    );

    `XSR_ASSERT_NEXT(a_push_shows, push, steps.valid)
    `XSR_ASSERT_IMPLIES(a_push_has_room, push, can_push && take && in_beat.last)
    `XSR_ASSERT_IMPLIES(a_error_clear,
        steps.valid && steps.status == ST_ERROR,
        steps.step_type == AXIS_UNKNOWN && !steps.name_given &&
        steps.name_len == 8'd0 && steps.value_len == 8'd0)
    `XSR_ASSERT_IMPLIES(a_no_name_zero,
        steps.valid && !steps.name_given,
        steps.name_start == 8'd0 && steps.name_len == 8'd0)

endmodule

`default_nettype wire

FILE: tb/sv/xsr_step_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// XPath step recognizer checker
// Watches the character and step channels, runs its own parser on every
// accepted character beat and compares each step beat, field by field, with
// the oldest predicted step. Mismatches and unexpected beats are counted.
// ---------------------------------------------------------------------------
module xsr_step_checker (
    input  logic clk,
    input  logic rst_n,
    xsr_char_if  chars,
    xsr_step_if  steps,
    output int   fails,
    output int   pending,
    output int   checked
);
    import xsr_pkg::*;

    typedef enum logic [3:0] {
        PH_STEP_AXIS, PH_STEP_NSTART, PH_STEP_NAME,
        PH_PRED_AXIS, PH_PRED_NSTART, PH_PRED_NAME,
        PH_PRED_EQ, PH_PRED_QUOTE, PH_PRED_VALUE,
        PH_DONE, PH_ERROR
    } parse_phase_t;

    localparam logic [1:0] AXIS_CHILD  = 2'd2;
    localparam logic [1:0] AXIS_PARENT = 2'd3;

    typedef struct packed {
        logic [1:0]       status;
        logic [1:0]       step_type;
        logic             name_given;
        logic [POS_W-1:0] name_start;
        logic [POS_W-1:0] name_len;
        logic [1:0]       pred_type;
        logic             pred_given;
        logic [POS_W-1:0] pred_start;
        logic [POS_W-1:0] pred_len;
        logic [POS_W-1:0] value_start;
        logic [POS_W-1:0] value_len;
    } step_acc_t;

    string      kw_word [3] = '{"attribute::", "child::", "parent::"};
    logic [1:0] kw_axis [3] = '{AXIS_ATTRIBUTE, AXIS_CHILD, AXIS_PARENT};

    parse_phase_t     phase_q;
    logic [POS_W-1:0] char_pos;
    logic [2:0]       kw_alive;
    int               kw_idx;
    logic [7:0]       quote_code;
    logic             zero_seen;
    step_acc_t        acc;
    res_t             expected_steps [$];

    function automatic void clear_parse();
        phase_q    = PH_STEP_AXIS;
        char_pos   = '0;
        kw_alive   = 3'b111;
        kw_idx     = 0;
        quote_code = '0;
        zero_seen  = 1'b0;
        acc        = '0;
    endfunction

    function automatic void open_predicate(input logic [POS_W-1:0] start);
        phase_q        = PH_PRED_AXIS;
        acc.pred_start = start;
        kw_alive       = 3'b111;
        kw_idx         = 0;
    endfunction

    function automatic void close_with(input logic [1:0] st);
        acc.status = st;
        phase_q    = PH_DONE;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic ends_name(input logic [7:0] c);
        return (c == CH_LBRACK) || (c == CH_EQ) || (c == CH_RBRACK) || is_space(c);
    endfunction

    function automatic logic [7:0] clip8(input logic [POS_W-1:0] v);
        return (v > POS_W'(255)) ? 8'hFF : v[7:0];
    endfunction

    function automatic void advance_parse(input logic [7:0] c, input logic [POS_W-1:0] pos);
        logic       again;
        logic       in_pred;
        logic [2:0] alive;
        again = 1'b1;
        while (again) begin
            again   = 1'b0;
            in_pred = (phase_q >= PH_PRED_AXIS);
            case (phase_q)
                PH_STEP_AXIS, PH_PRED_AXIS:
                begin
                    if (kw_idx == 0 && c == CH_AT) begin
                        if (in_pred) acc.pred_type = AXIS_ATTRIBUTE;
                        else acc.step_type = AXIS_ATTRIBUTE;
                        phase_q = in_pred ? PH_PRED_NSTART : PH_STEP_NSTART;
                    end else begin
                        alive = kw_alive;
                        for (int k = 0; k < 3; k++)
                            if (alive[k] && (kw_idx >= kw_word[k].len() ||
                                             8'(kw_word[k][kw_idx]) != c))
                                alive[k] = 1'b0;
                        if (alive == 3'b000) begin
                            if (kw_idx == 0) begin
                                phase_q = in_pred ? PH_PRED_NSTART : PH_STEP_NSTART;
                            end else begin
                                if (in_pred) acc.pred_given = 1'b1;
                                else acc.name_given = 1'b1;
                                phase_q = in_pred ? PH_PRED_NAME : PH_STEP_NAME;
                            end
                            again = 1'b1;
                        end else begin
                            kw_alive = alive;
                            kw_idx++;
                            for (int k = 0; k < 3; k++)
                                if (alive[k] && kw_idx == kw_word[k].len()) begin
                                    if (in_pred) acc.pred_type = kw_axis[k];
                                    else acc.step_type = kw_axis[k];
                                    phase_q = in_pred ? PH_PRED_NSTART : PH_STEP_NSTART;
                                end
                        end
                    end
                end
                PH_STEP_NSTART, PH_PRED_NSTART:
                begin
                    if (c == CH_LBRACK) begin
                        if (in_pred) close_with(ST_PRED);
                        else open_predicate(pos + 1'b1);
                    end else if (in_pred) begin
                        acc.pred_given = 1'b1;
                        acc.pred_start = pos;
                        phase_q        = PH_PRED_NAME;
                        again          = 1'b1;
                    end else begin
                        acc.name_given = 1'b1;
                        acc.name_start = pos;
                        phase_q        = PH_STEP_NAME;
                        again          = 1'b1;
                    end
                end
                PH_STEP_NAME:
                begin
                    if (ends_name(c)) begin
                        acc.name_len = pos - acc.name_start;
                        if (c == CH_LBRACK) open_predicate(pos + 1'b1);
                        else close_with(ST_OK);
                    end
                end
                PH_PRED_NAME:
                begin
                    if (ends_name(c)) begin
                        acc.pred_len = pos - acc.pred_start;
                        phase_q      = PH_PRED_EQ;
                        again        = 1'b1;
                    end
                end
                PH_PRED_EQ:
                begin
                    if (!is_space(c)) begin
                        if (c == CH_EQ) phase_q = PH_PRED_QUOTE;
                        else close_with(ST_PRED);
                    end
                end
                PH_PRED_QUOTE:
                begin
                    if (!is_space(c)) begin
                        quote_code      = c;
                        acc.value_start = pos + 1'b1;
                        phase_q         = PH_PRED_VALUE;
                    end
                end
                PH_PRED_VALUE:
                begin
                    if (c == quote_code) begin
                        acc.value_len = pos - acc.value_start;
                        close_with(ST_VALUE);
                    end
                end
                default:
                begin
                end
            endcase
        end
    endfunction

    function automatic void finish_expression(input logic [POS_W-1:0] pos);
        case (phase_q)
            PH_STEP_AXIS:
            begin
                if (pos == '0) begin
                    phase_q = PH_ERROR;
                end else begin
                    acc.name_given = 1'b1;
                    acc.name_len   = POS_W'(kw_idx);
                    close_with(ST_OK);
                end
            end
            PH_PRED_AXIS:
            begin
                if (kw_idx > 0) begin
                    acc.pred_given = 1'b1;
                    acc.pred_len   = POS_W'(kw_idx);
                end
                close_with(ST_PRED);
            end
            PH_STEP_NSTART: close_with(ST_OK);
            PH_PRED_NSTART: close_with(ST_PRED);
            PH_STEP_NAME:
            begin
                acc.name_len = pos - acc.name_start;
                close_with(ST_OK);
            end
            PH_PRED_NAME:
            begin
                acc.pred_len = pos - acc.pred_start;
                close_with(ST_PRED);
            end
            PH_PRED_EQ: close_with(ST_PRED);
            PH_DONE:
            begin
            end
            default: phase_q = PH_ERROR;
        endcase
    endfunction

    function automatic logic take_char(input logic [7:0] c, input logic fin, output res_t r);
        r = '0;
        if (!zero_seen) begin
            if (c == 8'h00) begin
                zero_seen = 1'b1;
            end else if (char_pos < POS_W'(MAX_LEN)) begin
                if (phase_q != PH_ERROR) advance_parse(c, char_pos);
                char_pos++;
            end else begin
                phase_q = PH_ERROR;
            end
        end
        if (!fin) return 1'b0;
        finish_expression(char_pos);
        if (phase_q == PH_ERROR) begin
            r.status = ST_ERROR;
        end else begin
            r.status     = acc.status;
            r.step_type  = acc.step_type;
            r.name_given = acc.name_given;
            if (acc.name_given) begin
                r.name_start = clip8(acc.name_start);
                r.name_len   = clip8(acc.name_len);
            end
            if (acc.status == ST_PRED || acc.status == ST_VALUE) begin
                r.pred_type       = acc.pred_type;
                r.pred_name_given = acc.pred_given;
                if (acc.pred_given) begin
                    r.pred_name_start = clip8(acc.pred_start);
                    r.pred_name_len   = clip8(acc.pred_len);
                end
            end
            if (acc.status == ST_VALUE) begin
                r.value_start = clip8(acc.value_start);
                r.value_len   = clip8(acc.value_len);
            end
        end
        clear_parse();
        return 1'b1;
    endfunction

    function automatic void check_field(input string fname, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", fname, want, got);
            fails++;
        end
    endfunction

    always @(posedge clk) begin
        res_t want;
        if (!rst_n) begin
            clear_parse();
            expected_steps.delete();
            fails   = 0;
            checked = 0;
        end else begin
            if (chars.valid && chars.ready)
                if (take_char(chars.char_code, chars.last, want))
                    expected_steps.push_back(want);
            if (steps.valid && steps.ready) begin
                if (expected_steps.size() == 0) begin
                    $error("step beat with no expression pending");
                    fails++;
                end else begin
                    want = expected_steps.pop_front();
                    check_field("status", want.status, steps.status);
                    check_field("step_type", want.step_type, steps.step_type);
                    check_field("name_given", want.name_given, steps.name_given);
                    check_field("name_start", want.name_start, steps.name_start);
                    check_field("name_len", want.name_len, steps.name_len);
                    check_field("pred_type", want.pred_type, steps.pred_type);
                    check_field("pred_name_given", want.pred_name_given,
                                steps.pred_name_given);
                    check_field("pred_name_start", want.pred_name_start,
                                steps.pred_name_start);
                    check_field("pred_name_len", want.pred_name_len, steps.pred_name_len);
                    check_field("value_start", want.value_start, steps.value_start);
                    check_field("value_len", want.value_len, steps.value_len);
                    checked++;
                end
            end
        end
        pending = expected_steps.size();
    end

endmodule

FILE: tb/sv/tb_xpath_step_recognizer_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// XPath step recognizer testbench
// Feeds directed and randomly built XPath steps, one character per beat, with
// bursty input and a stalling result side; the checker predicts and compares.
// ---------------------------------------------------------------------------
module tb_xpath_step_recognizer_top;
    import xsr_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_CHARS = 230;
    localparam int MIN_EXPRS    = 20;

    logic        clk;
    logic        rst_n;
    int          fails;
    int          pending;
    int          checked;
    int          cycles = 0;
    int          sent_chars = 0;
    int          sent_exprs = 0;
    int          burst_left = 0;
    logic [15:0] stall_mask = 16'h0;
    logic [7:0]  expr_chars [$];
    string       kw_text [3] = '{"attribute::", "child::", "parent::"};
    string       name_set = "abcdefghijklmnopqrstuvwxyz0123456789_-.:*@";

    xsr_char_if chars ();
    xsr_step_if steps ();

    xpath_step_recognizer_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars),
        .steps (steps)
    );

    xsr_step_checker u_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars),
        .steps   (steps),
        .fails   (fails),
        .pending (pending),
        .checked (checked)
    );

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $error("no progress after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // bit 0 of the mask stays clear so ready rises at least once in every pattern period
    always @(negedge clk) begin
        if (cycles % 96 == 0)
            stall_mask = ($urandom_range(0, 3) == 0) ? 16'h0 : (16'($urandom) & 16'hFFFE);
        steps.ready <= ~stall_mask[cycles % 16];
    end

    task automatic send_beat(input logic [7:0] c, input logic fin);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                chars.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 12);
        end
        chars.valid     <= 1'b1;
        chars.char_code <= c;
        chars.last      <= fin;
        @(posedge clk);
        while (!chars.ready) @(posedge clk);
        @(negedge clk);
        burst_left--;
        sent_chars++;
    endtask

    task automatic send_expr();
        if (expr_chars.size() == 0) expr_chars.push_back(8'h00);
        foreach (expr_chars[i]) send_beat(expr_chars[i], i == expr_chars.size() - 1);
        expr_chars.delete();
        sent_exprs++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) expr_chars.push_back(s[i]);
        send_expr();
    endtask

    function automatic void add_str(input string s, input int n);
        for (int i = 0; i < n; i++) expr_chars.push_back(s[i]);
    endfunction

    function automatic void add_ws(input int most);
        int n;
        n = $urandom_range(0, most);
        for (int i = 0; i < n; i++)
            expr_chars.push_back(($urandom_range(0, 1) == 0) ? CH_SPACE
                                 : 8'($urandom_range(CH_TAB, CH_CR)));
    endfunction

    function automatic logic [7:0] name_char();
        if ($urandom_range(0, 5) == 0) return 8'($urandom_range(1, 255));
        return name_set[$urandom_range(0, name_set.len() - 1)];
    endfunction

    function automatic void add_axis();
        int pick;
        int k;
        pick = $urandom_range(0, 9);
        k    = $urandom_range(0, 2);
        if (pick == 3) expr_chars.push_back(CH_AT);
        else if (pick >= 4 && pick <= 6) add_str(kw_text[pick - 4], kw_text[pick - 4].len());
        else if (pick >= 7) add_str(kw_text[k], $urandom_range(1, kw_text[k].len() - 1));
    endfunction

    function automatic void add_name();
        int n;
        n = $urandom_range(0, 5);
        for (int i = 0; i < n; i++) expr_chars.push_back(name_char());
    endfunction

    function automatic void add_value();
        logic [7:0] q;
        logic [7:0] c;
        int         n;
        case ($urandom_range(0, 2))
            0:       q = 8'h27;
            1:       q = 8'h22;
            default: q = 8'($urandom_range(1, 255));
        endcase
        expr_chars.push_back(q);
        n = $urandom_range(0, 5);
        for (int i = 0; i < n; i++) begin
            c = name_char();
            expr_chars.push_back((c == q) ? 8'h78 : c);
        end
        expr_chars.push_back(q);
    endfunction

    function automatic void build_expression();
        int n;
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) expr_chars.push_back(8'($urandom));
            return;
        end
        add_axis();
        add_name();
        if ($urandom_range(0, 3) != 0) begin
            if ($urandom_range(0, 7) == 0) add_ws(2);
            expr_chars.push_back(CH_LBRACK);
            if ($urandom_range(0, 9) == 0) add_ws(1);
            add_axis();
            add_name();
            if ($urandom_range(0, 3) == 0) add_ws(2);
            if ($urandom_range(0, 2) != 0) begin
                expr_chars.push_back(CH_EQ);
                add_ws(2);
                add_value();
            end
            if ($urandom_range(0, 1) == 0) expr_chars.push_back(CH_RBRACK);
        end
        if ($urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) expr_chars.push_back(8'($urandom));
        end
        if ($urandom_range(0, 6) == 0 && expr_chars.size() > 1) begin
            n = $urandom_range(1, expr_chars.size() - 1);
            while (expr_chars.size() > n) void'(expr_chars.pop_back());
        end
        if ($urandom_range(0, 11) == 0 && expr_chars.size() > 0)
            expr_chars.insert($urandom_range(0, expr_chars.size() - 1), 8'h00);
    endfunction

    function automatic void build_long(input int len);
        for (int i = 0; i < len; i++) expr_chars.push_back(8'($urandom_range(8'h61, 8'h7A)));
    endfunction

    initial
    begin
        int longs;
        int short_chars;
        int rand_exprs;
        int long_len [2];
        long_len        = '{256, 257};
        longs           = 0;
        short_chars     = 0;
        rand_exprs      = 0;
        rst_n           = 1'b0;
        chars.valid     = 1'b0;
        chars.char_code = 8'h00;
        chars.last      = 1'b0;
        steps.ready     = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_text("");
        send_text("@");
        send_text("par");
        send_text("x[@k='v']");
        send_text("[ ]");
        send_text("a[b=\"v");

        while (short_chars < RANDOM_CHARS || rand_exprs < MIN_EXPRS) begin
            if (rand_exprs % 10 == 5 && longs < 2) begin
                build_long(long_len[longs]);
                longs++;
            end else begin
                build_expression();
                short_chars += expr_chars.size();
            end
            send_expr();
            rand_exprs++;
        end
        chars.valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        $display("Sent %0d characters in %0d expressions, %0d of them at or past the length limit.",
                 sent_chars, sent_exprs, longs);
        $display("Compared %0d step results under bursty input and result stalls.", checked);
        if (fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
